// ===== hw/rtl/modexp_pkg.sv =====
package modexp_pkg;

  localparam int BASE_BITS  = 16;
  localparam int OUT_BITS   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] EXP_RESET = 64'd65537;

  typedef logic [BASE_BITS-1:0] base_t;
  typedef logic [OUT_BITS-1:0]  result_t;

endpackage

// ===== hw/rtl/modular_exponentiation.sv =====
// channel | direction | handshake           | payload
// input   | in        | start && !busy      | in_base_value
// result  | out       | out_valid (1 cycle) | out_power_result
// config  | in        | cfg_valid/cfg_ready | cfg_index, cfg_wdata
//
// the work on each base is, in order:
// a bit-serial reduction of the base, then per exponent bit one pass of two
// bit-serial modular multipliers (multiply and square) running side by side.
// the result strobes for one cycle at the edge where busy falls; a new start
// may be taken in that same cycle. reset (synchronous, rst_n low) returns to idle
// with modulus 1 and exponent 65537. the receiver cannot stall the result.
module modular_exponentiation #(
  parameter int MOD_BITS = 16,
  parameter int EXP_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  modexp_pkg::base_t                   in_base_value,
  output logic                                out_valid,
  output modexp_pkg::result_t                 out_power_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [modexp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [modexp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import modexp_pkg::*;

  localparam int INNER_MAX = (MOD_BITS > BASE_BITS) ? MOD_BITS : BASE_BITS;
  localparam int CNT_W     = $clog2(INNER_MAX);
  localparam int ECNT_W    = $clog2(EXP_BITS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_MULT   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [MOD_BITS-1:0] modulus_r;
  logic [EXP_BITS-1:0] exponent_r;
  logic [EXP_BITS-1:0] exp_sh_r, exp_sh_nxt;
  logic [BASE_BITS-1:0] base_sh_r, base_sh_nxt;
  logic [MOD_BITS-1:0] acc_r, acc_nxt;
  logic [MOD_BITS-1:0] sq_r, sq_nxt;
  logic [MOD_BITS-1:0] acc_sh_r, acc_sh_nxt;
  logic [MOD_BITS-1:0] sq_sh_r, sq_sh_nxt;
  logic [MOD_BITS-1:0] pa_r, pa_nxt;
  logic [MOD_BITS-1:0] ps_r, ps_nxt;
  logic [CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [ECNT_W-1:0]   exp_cnt_r, exp_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_power_result_r, out_power_result_nxt;
  logic [MOD_BITS-1:0] step_a, step_s;

  // one bit of interleaved modular multiplication: (2r + bit*b) mod m
  function automatic logic [MOD_BITS-1:0] dbl_add(
    input logic [MOD_BITS-1:0] r,
    input logic                bit_in,
    input logic [MOD_BITS-1:0] b,
    input logic [MOD_BITS-1:0] m
  );
    logic [MOD_BITS:0] t;
    logic [MOD_BITS:0] u;
    t = {r, 1'b0};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    u = bit_in ? t + {1'b0, b} : t;
    if (u >= {1'b0, m}) u = u - {1'b0, m};
    return u[MOD_BITS-1:0];
  endfunction

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_power_result = out_power_result_r;

  // reduction reuses the multiply datapath with an addend of one
  assign step_a = (state_r == ST_REDUCE)
                ? dbl_add(pa_r, base_sh_r[BASE_BITS-1], MOD_BITS'(1), modulus_r)
                : dbl_add(pa_r, acc_sh_r[MOD_BITS-1], sq_r, modulus_r);
  assign step_s = dbl_add(ps_r, sq_sh_r[MOD_BITS-1], sq_r, modulus_r);

  always_comb begin
    state_nxt            = state_r;
    exp_sh_nxt           = exp_sh_r;
    base_sh_nxt          = base_sh_r;
    acc_nxt              = acc_r;
    sq_nxt               = sq_r;
    acc_sh_nxt           = acc_sh_r;
    sq_sh_nxt            = sq_sh_r;
    pa_nxt               = pa_r;
    ps_nxt               = ps_r;
    bit_cnt_nxt          = bit_cnt_r;
    exp_cnt_nxt          = exp_cnt_r;
    out_valid_nxt        = 1'b0;
    out_power_result_nxt = out_power_result_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          base_sh_nxt = in_base_value;
          exp_sh_nxt  = exponent_r;
          pa_nxt      = '0;
          bit_cnt_nxt = '0;
          state_nxt   = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        base_sh_nxt = base_sh_r << 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        pa_nxt      = step_a;
        if (bit_cnt_r == CNT_W'(BASE_BITS - 1)) begin
          sq_nxt      = step_a;
          sq_sh_nxt   = step_a;
          acc_nxt     = MOD_BITS'(1);
          acc_sh_nxt  = MOD_BITS'(1);
          pa_nxt      = '0;
          ps_nxt      = '0;
          bit_cnt_nxt = '0;
          exp_cnt_nxt = '0;
          state_nxt   = ST_MULT;
        end
      end
      ST_MULT: begin
        acc_sh_nxt  = acc_sh_r << 1;
        sq_sh_nxt   = sq_sh_r << 1;
        pa_nxt      = step_a;
        ps_nxt      = step_s;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == CNT_W'(MOD_BITS - 1)) begin
          // end of one exponent bit: commit multiply if set, always commit square
          acc_nxt     = exp_sh_r[0] ? step_a : acc_r;
          sq_nxt      = step_s;
          acc_sh_nxt  = exp_sh_r[0] ? step_a : acc_r;
          sq_sh_nxt   = step_s;
          pa_nxt      = '0;
          ps_nxt      = '0;
          bit_cnt_nxt = '0;
          exp_sh_nxt  = exp_sh_r >> 1;
          exp_cnt_nxt = exp_cnt_r + 1'b1;
          if (exp_cnt_r == ECNT_W'(EXP_BITS - 1)) begin
            out_valid_nxt        = 1'b1;
            out_power_result_nxt = OUT_BITS'(exp_sh_r[0] ? step_a : acc_r);
            state_nxt            = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MOD_BITS'(1);
      exponent_r  <= EXP_BITS'(EXP_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MODULUS) begin
          // a zero modulus is dropped so the register never holds it
          if (cfg_wdata[MOD_BITS-1:0] != '0) modulus_r <= cfg_wdata[MOD_BITS-1:0];
        end else if (cfg_index == REG_EXPONENT) begin
          exponent_r <= cfg_wdata[EXP_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    exp_sh_r           <= exp_sh_nxt;
    base_sh_r          <= base_sh_nxt;
    acc_r              <= acc_nxt;
    sq_r               <= sq_nxt;
    acc_sh_r           <= acc_sh_nxt;
    sq_sh_r            <= sq_sh_nxt;
    pa_r               <= pa_nxt;
    ps_r               <= ps_nxt;
    bit_cnt_r          <= bit_cnt_nxt;
    exp_cnt_r          <= exp_cnt_nxt;
    out_power_result_r <= out_power_result_nxt;
  end

endmodule

// ===== test/modular_exponentiation_test.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_test;
  import modexp_pkg::*;

  localparam int MOD_W = 16;
  localparam int EXP_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_CYCLES = 600;
  localparam int CYCLE_LIMIT = 3_000_000;
  // no idling on either side inside this window
  localparam int QUIET_FROM = 150_000;
  localparam int QUIET_TO = 250_000;

  typedef struct {
    base_t   base;
    result_t power;
  } power_check_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  base_t in_base_value = '0;
  logic out_valid;
  result_t out_power_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  base_t pending_bases[$];
  power_check_t expected_powers[$];
  logic [MOD_W-1:0] modulus_q = 16'd1;
  logic [EXP_W-1:0] exponent_q = EXP_RESET[EXP_W-1:0];
  int unsigned cycle_count = 0;
  int error_count = 0;

  modular_exponentiation #(
    .MOD_BITS(MOD_W),
    .EXP_BITS(EXP_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_base_value(in_base_value),
    .out_valid(out_valid),
    .out_power_result(out_power_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit take_break();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 8;
  endfunction

  // right-to-left square and multiply with wide products
  function automatic result_t mod_power(base_t b);
    longint unsigned m;
    longint unsigned sq;
    longint unsigned acc;
    m = modulus_q;
    sq = b % m;
    acc = 1;
    for (int i = 0; i < EXP_W; i++) begin
      if (exponent_q[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return result_t'(acc);
  endfunction

  function automatic base_t pick_base();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return base_t'(modulus_q - 1);
      3: return base_t'(modulus_q * $urandom_range(65535 / modulus_q));
      default: return base_t'($urandom);
    endcase
  endfunction

  // driver: holds start with the head base until the block takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_powers.push_back(power_check_t'{base: in_base_value,
                                                 power: mod_power(in_base_value)});
      if (!(start && busy)) begin
        if (pending_bases.size() != 0 && !take_break()) begin
          start <= 1'b1;
          in_base_value <= pending_bases.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    power_check_t want;
    if (rst_n && out_valid) begin
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected power_result: expected none, actual %0d",
                 $time, out_power_result);
        error_count++;
      end else begin
        want = expected_powers.pop_front();
        if (out_power_result !== want.power) begin
          $display("%0t: power_result mismatch for base %0d: expected %0d, actual %0d",
                   $time, want.base, want.power, out_power_result);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d power results outstanding", $time,
               expected_powers.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bases.size() != 0 || start || expected_powers.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    while (take_break()) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MODULUS) begin
      // a zero modulus is dropped by the block
      if (data[MOD_W-1:0] != '0) modulus_q = data[MOD_W-1:0];
    end else if (idx == REG_EXPONENT) begin
      exponent_q = data[EXP_W-1:0];
    end
  endtask

  task automatic randomize_config();
    logic [CFG_DATA_W-1:0] mod_data;
    logic [CFG_DATA_W-1:0] exp_data;
    logic [MOD_W-1:0] m;
    logic [EXP_W-1:0] e;
    case ($urandom_range(6))
      0: m = 16'd1;
      1: m = 16'd2;
      2: m = '1;
      3: m = 16'd65521;
      4: m = '0;
      5: m = MOD_W'($urandom_range(300, 3));
      default: m = MOD_W'($urandom_range(65535, 1));
    endcase
    case ($urandom_range(6))
      0: e = '0;
      1: e = 32'd1;
      2: e = 32'd2;
      3: e = 32'd65537;
      4: e = '1;
      5: e = EXP_W'($urandom_range(255));
      default: e = $urandom;
    endcase
    // junk above the register widths must be dropped
    mod_data = {$urandom, $urandom};
    mod_data[MOD_W-1:0] = m;
    exp_data = {$urandom, $urandom};
    exp_data[EXP_W-1:0] = e;
    if ($urandom_range(1)) begin
      if ($urandom_range(3) != 0) write_reg(REG_MODULUS, mod_data);
      if ($urandom_range(3) != 0) write_reg(REG_EXPONENT, exp_data);
    end else begin
      if ($urandom_range(3) != 0) write_reg(REG_EXPONENT, exp_data);
      if ($urandom_range(3) != 0) write_reg(REG_MODULUS, mod_data);
    end
    if ($urandom_range(3) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
  endtask

  initial begin
    int issued;
    int phase_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: modulus one gives zero
    pending_bases = '{16'd0, 16'hFFFF, 16'd12345};
    wait_idle();

    // zero exponent gives one
    write_reg(REG_MODULUS, 64'd65535);
    write_reg(REG_EXPONENT, 64'd0);
    pending_bases = '{16'd0, 16'hFFFF, 16'd1};
    wait_idle();

    write_reg(REG_EXPONENT, 64'hFFFF_FFFF);
    pending_bases = '{16'd2, 16'hFFFE, 16'hFFFF, 16'd0};
    wait_idle();

    // base above the modulus is reduced first
    write_reg(REG_MODULUS, 64'd65521);
    write_reg(REG_EXPONENT, 64'd1);
    pending_bases = '{16'hFFFF, 16'd65520, 16'h8000};
    wait_idle();

    // zero modulus ignored, high bits of exponent ignored
    write_reg(REG_MODULUS, 64'd0);
    write_reg(REG_EXPONENT, 64'hFFFF_FFFF_0001_0001);
    pending_bases = '{16'd3, 16'hFFFF};
    wait_idle();

    // writes beyond the register list do nothing
    write_reg(REG_MODULUS, 64'hABCD_0000_0000_0002);
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '1);
    write_reg(REG_EXPONENT, 64'd2);
    pending_bases = '{16'd1, 16'hFFFF, 16'hFFFE};
    wait_idle();

    // modulus one with zero exponent still gives one
    write_reg(REG_MODULUS, 64'd1);
    write_reg(REG_EXPONENT, 64'd0);
    pending_bases = '{16'd7};
    wait_idle();
    write_reg(REG_EXPONENT, 64'd1);
    pending_bases = '{16'd7};

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      wait_idle();
      randomize_config();
      phase_len = $urandom_range(80, 20);
      repeat (phase_len) pending_bases.push_back(pick_base());
      issued += phase_len;
    end
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_powers.size() != 0) begin
      $display("%0t: power results missing: expected %0d more, actual 0", $time,
               expected_powers.size());
      error_count++;
    end
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/modexp_pkg.sv
hw/rtl/modular_exponentiation.sv
test/modular_exponentiation_test.sv
